// ===== rtl/core/keyword_hash_table_assert.svh =====
// keyword_hash_table_assert.svh: assertion macros for the keyword table rtl
// expects i_clk and i_rst_n in the scope of each use
`ifndef KEYWORD_HASH_TABLE_ASSERT_SVH
`define KEYWORD_HASH_TABLE_ASSERT_SVH

// condition implies consequence in the same cycle
`define KHT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define KHT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/kht_pkg.sv =====
// kht_pkg: shared types and constants of the keyword hash table
// no dependencies
package kht_pkg;

    localparam logic [31:0] HASH_SEED = 32'd5381;
    localparam logic [5:0]  HASH_MUL  = 6'd33;
    localparam int          TYPE_W    = 10;

    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_INSERT = 1'b1;

    typedef enum logic [2:0] {
        ST_HIT      = 3'd0,
        ST_MISS     = 3'd1,
        ST_INSERTED = 3'd2,
        ST_FULL     = 3'd3,
        ST_TOO_LONG = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_READ,
        BK_CHECK
    } t_back_state;

endpackage

// ===== rtl/core/kht_front.sv =====
// kht_front: hashes key bytes, buffers the key and builds one probe job per key
// depends on kht_pkg
module kht_front import kht_pkg::*; #(
    parameter int TABLE_SLOTS = 512,
    parameter int MAX_KEY_LEN = 16,
    parameter int SLOT_W      = $clog2(TABLE_SLOTS),
    parameter int LEN_W       = $clog2(MAX_KEY_LEN + 1),
    parameter int KEY_BITS    = 8 * MAX_KEY_LEN,
    parameter int JOB_W       = 1 + TYPE_W + SLOT_W + LEN_W + KEY_BITS + 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_mode,
    input  logic [7:0]        i_key_byte,
    input  logic              i_last,
    input  logic [TYPE_W-1:0] i_token_type,
    output logic              o_push,
    output logic [JOB_W-1:0]  o_job
);

    localparam int CNT_W = $clog2(MAX_KEY_LEN + 2);
    localparam int KI_W  = $clog2(MAX_KEY_LEN);

    logic [31:0]      r_hash, n_hash;
    logic [CNT_W-1:0] r_cnt;
    logic [7:0]       r_buf [MAX_KEY_LEN];
    logic             room;
    logic             too_long;
    logic [KEY_BITS-1:0] key_packed;

    assign room   = (r_cnt < CNT_W'(MAX_KEY_LEN));
    assign n_hash = 32'(r_hash * HASH_MUL) + {24'd0, i_key_byte};

    // hash and byte count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= HASH_SEED;
            r_cnt  <= '0;
        end else if (i_accept) begin
            if (i_last) begin
                r_hash <= HASH_SEED;
                r_cnt  <= '0;
            end else begin
                r_hash <= n_hash;
                r_cnt  <= room ? r_cnt + 1'b1 : CNT_W'(MAX_KEY_LEN + 1);
            end
        end
    end

    // key byte buffer
    always_ff @(posedge i_clk) begin
        if (i_accept && room) begin
            r_buf[r_cnt[KI_W-1:0]] <= i_key_byte;
        end
    end

    // key bytes below the length, current byte in place, zero above
    always_comb begin
        for (int i = 0; i < MAX_KEY_LEN; i++) begin
            if (CNT_W'(i) == r_cnt) begin
                key_packed[i*8 +: 8] = i_key_byte;
            end else if (CNT_W'(i) < r_cnt) begin
                key_packed[i*8 +: 8] = r_buf[i];
            end else begin
                key_packed[i*8 +: 8] = 8'd0;
            end
        end
    end

    assign too_long = !room;
    assign o_push   = i_accept && i_last;
    assign o_job    = {i_mode, i_token_type, n_hash[SLOT_W-1:0],
                       LEN_W'(r_cnt + 1'b1), key_packed, too_long};

endmodule

// ===== rtl/core/kht_queue.sv =====
// kht_queue: two-entry job queue between the front and the back
// depends on nothing but its width parameter
module kht_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_count;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rp];

endmodule

// ===== rtl/core/kht_back.sv =====
// kht_back: slot memory, clearing pass and linear probe sequencer
// depends on kht_pkg and keyword_hash_table_assert.svh
`include "keyword_hash_table_assert.svh"
module kht_back import kht_pkg::*; #(
    parameter int TABLE_SLOTS = 512,
    parameter int MAX_KEY_LEN = 16,
    parameter int SLOT_W      = $clog2(TABLE_SLOTS),
    parameter int LEN_W       = $clog2(MAX_KEY_LEN + 1),
    parameter int KEY_BITS    = 8 * MAX_KEY_LEN,
    parameter int JOB_W       = 1 + TYPE_W + SLOT_W + LEN_W + KEY_BITS + 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    input  logic [JOB_W-1:0]  i_job,
    output logic              o_pop,
    output logic              o_clearing,
    output logic              o_out_valid,
    output t_status           o_status,
    output logic [TYPE_W-1:0] o_found_type,
    input  logic              i_out_stall
);

    localparam int ENT_W = 1 + TYPE_W + LEN_W + KEY_BITS;

    t_back_state r_state, n_state;
    logic [SLOT_W-1:0] r_probe, n_probe;
    logic [SLOT_W-1:0] r_cnt, n_cnt;
    logic [SLOT_W-1:0] r_clr, n_clr;
    logic              r_out_valid;
    t_status           r_status;
    logic [TYPE_W-1:0] r_found;

    logic [ENT_W-1:0]  r_mem [TABLE_SLOTS];
    logic [ENT_W-1:0]  r_rd;

    logic                job_mode, job_too_long;
    logic [TYPE_W-1:0]   job_type;
    logic [SLOT_W-1:0]   job_home;
    logic [LEN_W-1:0]    job_len;
    logic [KEY_BITS-1:0] job_key;

    logic                rd_used;
    logic [TYPE_W-1:0]   rd_type;
    logic [LEN_W-1:0]    rd_len;
    logic [KEY_BITS-1:0] rd_key;

    logic              out_free, res_load, mem_we;
    t_status           res_status;
    logic [TYPE_W-1:0] res_found;
    logic [SLOT_W-1:0] mem_wa;
    logic [ENT_W-1:0]  mem_wd;

    assign {job_mode, job_type, job_home, job_len, job_key, job_too_long} = i_job;
    assign {rd_used, rd_type, rd_len, rd_key} = r_rd;
    assign out_free = !r_out_valid || !i_out_stall;

    // state and probe registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_CLEAR;
            r_clr   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_probe <= n_probe;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_status <= res_status;
            r_found  <= res_found;
        end
    end

    // slot memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == BK_READ) begin
            r_rd <= r_mem[r_probe];
        end
    end

    // probe sequencer
    always_comb begin
        n_state    = r_state;
        n_probe    = r_probe;
        n_cnt      = r_cnt;
        n_clr      = r_clr;
        o_pop      = 1'b0;
        res_load   = 1'b0;
        res_status = ST_MISS;
        res_found  = '0;
        mem_we     = 1'b0;
        mem_wa     = r_probe;
        mem_wd     = '0;
        unique case (r_state)
            BK_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr;
                n_clr  = r_clr + 1'b1;
                if (r_clr == SLOT_W'(TABLE_SLOTS - 1)) begin
                    n_state = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (i_job_valid) begin
                    if (job_too_long) begin
                        if (out_free) begin
                            res_load   = 1'b1;
                            res_status = (job_mode == MODE_INSERT) ? ST_TOO_LONG : ST_MISS;
                            o_pop      = 1'b1;
                        end
                    end else begin
                        n_probe = job_home;
                        n_cnt   = '0;
                        n_state = BK_READ;
                    end
                end
            end
            BK_READ: begin
                n_state = BK_CHECK;
            end
            BK_CHECK: begin
                priority if (!rd_used) begin
                    if (out_free) begin
                        res_load = 1'b1;
                        o_pop    = 1'b1;
                        n_state  = BK_IDLE;
                        if (job_mode == MODE_INSERT) begin
                            mem_we     = 1'b1;
                            mem_wd     = {1'b1, job_type, job_len, job_key};
                            res_status = ST_INSERTED;
                        end
                    end
                end else if (job_mode == MODE_LOOKUP && rd_len == job_len
                             && rd_key == job_key) begin
                    if (out_free) begin
                        res_load   = 1'b1;
                        res_status = ST_HIT;
                        res_found  = rd_type;
                        o_pop      = 1'b1;
                        n_state    = BK_IDLE;
                    end
                end else if (r_cnt == SLOT_W'(TABLE_SLOTS - 1)) begin
                    if (out_free) begin
                        res_load   = 1'b1;
                        res_status = (job_mode == MODE_INSERT) ? ST_FULL : ST_MISS;
                        o_pop      = 1'b1;
                        n_state    = BK_IDLE;
                    end
                end else begin
                    n_probe = r_probe + 1'b1;
                    n_cnt   = r_cnt + 1'b1;
                    n_state = BK_READ;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    assign o_clearing   = (r_state == BK_CLEAR);
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_found_type = r_found;

    // checks
    `KHT_ASSERT_SAME(a_we_state, mem_we, r_state == BK_CLEAR || r_state == BK_CHECK, "stray slot write")
    `KHT_ASSERT_SAME(a_pop_job, o_pop, i_job_valid, "job popped from empty queue")
    `KHT_ASSERT_NEXT(a_found_hit, res_load && res_status != ST_HIT, o_found_type == '0, "type on non-hit")

endmodule

// ===== rtl/core/keyword_hash_table.sv =====
// keyword_hash_table: top level of the keyword hash table
// depends on kht_pkg, kht_front, kht_queue and kht_back
//
// Open-addressed keyword table with djb2 hashing and linear probing. Key bytes
// transfer one per cycle on the input channel unless it stalls; the byte marked
// last closes the key and produces one result (hit, miss, inserted, table full,
// key too long). After reset the slot memory is cleared slot by slot, and the
// input stalls meanwhile. In the back end each probed slot goes through a read
// state and a check state, the check using the registered read of the slot
// memory; the front takes bytes meanwhile until its two-entry job queue fills.
// TABLE_SLOTS must be a power of two.
module keyword_hash_table import kht_pkg::*; #(
    parameter int TABLE_SLOTS = 512,
    parameter int MAX_KEY_LEN = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_mode,
    input  logic [7:0]        i_key_byte,
    input  logic              i_last,
    input  logic [TYPE_W-1:0] i_token_type,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [2:0]        o_status,
    output logic [TYPE_W-1:0] o_found_type
);

    localparam int SLOT_W   = $clog2(TABLE_SLOTS);
    localparam int LEN_W    = $clog2(MAX_KEY_LEN + 1);
    localparam int KEY_BITS = 8 * MAX_KEY_LEN;
    localparam int JOB_W    = 1 + TYPE_W + SLOT_W + LEN_W + KEY_BITS + 1;

    logic             accept, push, pop, q_full, q_valid, clearing;
    logic [JOB_W-1:0] job_in, job_out;
    t_status          status;

    // input transfer
    assign o_in_stall = clearing || q_full;
    assign accept     = i_in_valid && !o_in_stall;

    kht_front #(
        .TABLE_SLOTS(TABLE_SLOTS), .MAX_KEY_LEN(MAX_KEY_LEN),
        .SLOT_W(SLOT_W), .LEN_W(LEN_W), .KEY_BITS(KEY_BITS), .JOB_W(JOB_W)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_accept(accept),
        .i_mode(i_mode), .i_key_byte(i_key_byte), .i_last(i_last),
        .i_token_type(i_token_type), .o_push(push), .o_job(job_in)
    );

    kht_queue #(.WIDTH(JOB_W)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_data(job_in),
        .i_pop(pop), .o_full(q_full), .o_valid(q_valid), .o_data(job_out)
    );

    kht_back #(
        .TABLE_SLOTS(TABLE_SLOTS), .MAX_KEY_LEN(MAX_KEY_LEN),
        .SLOT_W(SLOT_W), .LEN_W(LEN_W), .KEY_BITS(KEY_BITS), .JOB_W(JOB_W)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_job_valid(q_valid), .i_job(job_out),
        .o_pop(pop), .o_clearing(clearing), .o_out_valid(o_out_valid),
        .o_status(status), .o_found_type(o_found_type), .i_out_stall(i_out_stall)
    );

    assign o_status = status;

endmodule
